FILE: rtl/maneuver_candidate_selector_top_macros.svh
// ----------------------------------------------------------------------------
// Maneuver candidate selector assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MANEUVER_CANDIDATE_SELECTOR_TOP_MACROS_SVH
`define MANEUVER_CANDIDATE_SELECTOR_TOP_MACROS_SVH

// Same-cycle implication.
`define MCS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mcs assertion failed");

// Next-cycle implication.
`define MCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mcs assertion failed");

`endif

FILE: rtl/mcs_pkg.sv
// ----------------------------------------------------------------------------
// mcs_pkg
// Types, codes and the per-key compare used by the candidate selector.
// ----------------------------------------------------------------------------
`default_nettype none

package mcs_pkg;

  localparam int IndexWidth = 16;
  localparam int ValWidth   = 32;
  localparam int TolWidth   = 16;
  localparam int DistWidth  = 31;
  localparam int TimeWidth  = 31;

  // Configuration register indexes.
  localparam logic REG_SOFT_DIST = 1'b0;
  localparam logic REG_TIE_TOL   = 1'b1;

  // Collision classes.
  localparam logic [1:0] CLASS_FREE = 2'd0;
  localparam logic [1:0] CLASS_SOFT = 2'd1;

  localparam logic [IndexWidth-1:0] NO_INDEX = '1;

  // Soft inflation distance after reset (0.5 m).
  localparam logic [DistWidth-1:0] SOFT_DIST_RESET = 31'd32768;
  localparam logic [TolWidth-1:0]  TIE_TOL_RESET   = 16'd1;

  typedef enum logic [1:0] {
    KEY_TIE  = 2'b00,
    KEY_WIN  = 2'b01,
    KEY_LOSE = 2'b10
  } key_res_t;

  // One prepared candidate, with its four ranking keys.
  typedef struct packed {
    logic                  valid;
    logic                  last;
    logic [IndexWidth-1:0] number;
    logic [ValWidth-1:0]   depth;
    logic [ValWidth-1:0]   pass_abs;
    logic [ValWidth-1:0]   term_abs;
    logic [TimeWidth-1:0]  travel;
  } cand_t;

  // A candidate wins a key when it is below the best by more than the
  // tolerance and loses when it is above by more than the tolerance.
  function automatic key_res_t key_cmp(input logic [ValWidth-1:0] cand,
                                       input logic [ValWidth-1:0] best,
                                       input logic [TolWidth-1:0] tol);
    logic [ValWidth+1:0] cand_ext;
    logic [ValWidth+1:0] best_ext;
    logic [ValWidth+1:0] tol_ext;
    key_res_t            res;
    cand_ext = {2'b00, cand};
    best_ext = {2'b00, best};
    tol_ext  = {{(ValWidth+2-TolWidth){1'b0}}, tol};
    if (cand_ext + tol_ext < best_ext) begin
      res = KEY_WIN;
    end else if (cand_ext > best_ext + tol_ext) begin
      res = KEY_LOSE;
    end else begin
      res = KEY_TIE;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/maneuver_candidate_selector_top.sv
// ----------------------------------------------------------------------------
// maneuver_candidate_selector_top
// Streams maneuver candidates and reports the best valid one of each set.
// ----------------------------------------------------------------------------
// Result path: the last beat of a set passes the input register and the
// compare stage, which loads the result register as that beat advances.
// Throughput: one candidate beat per cycle, limited by the single compare
// stage against the registered best; a last beat waits only while a previous
// result is still held in the result register.
// Reset: synchronous rst empties both stages, clears the running best and
// loads the soft inflation distance (0.5 m) and tolerance (one LSB).
// ----------------------------------------------------------------------------
`default_nettype none

module maneuver_candidate_selector_top (
  input  wire logic               clk,
  input  wire logic               rst,
  // Configuration write port.
  input  wire logic               cfg_write,
  input  wire logic               cfg_index,
  input  wire logic [30:0]        cfg_data,
  // Candidate channel.
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] cand_number,
  input  wire logic               velocity_ok,
  input  wire logic [1:0]         collision_class,
  input  wire logic signed [31:0] min_clearance,
  input  wire logic signed [31:0] passing_offset,
  input  wire logic signed [31:0] terminal_offset,
  input  wire logic [30:0]        travel_time,
  input  wire logic               last_item,
  // Result channel.
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    found,
  output logic signed [15:0]      chosen_index
);
  import mcs_pkg::*;

  logic [DistWidth-1:0] soft_dist;
  logic [TolWidth-1:0]  tol;
  logic                 cand_valid;
  logic                 cand_ready;
  cand_t                cand;

  // The user must write these registers only while no set is in flight (the
  // block does not enforce this), so both stages may read them directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      soft_dist <= SOFT_DIST_RESET;
      tol       <= TIE_TOL_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SOFT_DIST: soft_dist <= cfg_data;
        REG_TIE_TOL:   tol       <= cfg_data[TolWidth-1:0];
        default:       ;
      endcase
    end
  end

  // First stage: the beat is checked for validity and its ranking keys are
  // formed (inflation depth, absolute offsets) into the input register.
  mcs_prep u_prep (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .cand_number     (cand_number),
    .velocity_ok     (velocity_ok),
    .collision_class (collision_class),
    .min_clearance   (min_clearance),
    .passing_offset  (passing_offset),
    .terminal_offset (terminal_offset),
    .travel_time     (travel_time),
    .last_item       (last_item),
    .soft_dist       (soft_dist),
    .tol             (tol),
    .cand_valid      (cand_valid),
    .cand            (cand),
    .cand_ready      (cand_ready)
  );

  // Second stage: the four keys are compared combinationally against the running
  // best, and a last beat loads the result register and clears the best.
  mcs_best u_best (
    .clk          (clk),
    .rst          (rst),
    .tol          (tol),
    .cand_valid   (cand_valid),
    .cand         (cand),
    .cand_ready   (cand_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .chosen_index (chosen_index)
  );

endmodule

`default_nettype wire

FILE: rtl/mcs_prep.sv
// ----------------------------------------------------------------------------
// mcs_prep
// Input register stage: validity check, inflation depth and absolute offsets.
// ----------------------------------------------------------------------------
`default_nettype none

module mcs_prep (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [15:0]              cand_number,
  input  wire logic                            velocity_ok,
  input  wire logic [1:0]                      collision_class,
  input  wire logic signed [31:0]              min_clearance,
  input  wire logic signed [31:0]              passing_offset,
  input  wire logic signed [31:0]              terminal_offset,
  input  wire logic [30:0]                     travel_time,
  input  wire logic                            last_item,
  input  wire logic [mcs_pkg::DistWidth-1:0]   soft_dist,
  input  wire logic [mcs_pkg::TolWidth-1:0]    tol,
  output logic                                 cand_valid,
  output mcs_pkg::cand_t                       cand,
  input  wire logic                            cand_ready
);
  import mcs_pkg::*;

  cand_t                      cand_next;
  logic signed [ValWidth+1:0] diff;
  logic signed [ValWidth+1:0] tol_s;
  logic                       load;

  // Depth difference is at most 2^32 - 1, so it never needs saturation.
  always_comb begin
    diff  = $signed({3'b000, soft_dist}) - $signed({{2{min_clearance[31]}}, min_clearance});
    tol_s = $signed({{(ValWidth+2-TolWidth){1'b0}}, tol});
    cand_next.valid  = !cand_number[15] && velocity_ok &&
                       (collision_class == CLASS_FREE || collision_class == CLASS_SOFT);
    cand_next.last   = last_item;
    cand_next.number = cand_number;
    if (collision_class != CLASS_SOFT) begin
      cand_next.depth = '0;
    end else if (diff < tol_s) begin
      cand_next.depth = {{(ValWidth-TolWidth){1'b0}}, tol};
    end else begin
      cand_next.depth = diff[ValWidth-1:0];
    end
    cand_next.pass_abs = passing_offset[31] ? (~passing_offset + 32'd1) : passing_offset;
    cand_next.term_abs = terminal_offset[31] ? (~terminal_offset + 32'd1) : terminal_offset;
    cand_next.travel   = travel_time;
  end

  assign in_ready = !cand_valid || cand_ready;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_valid <= 1'b0;
    end else if (in_ready) begin
      cand_valid <= in_valid;
    end
    if (load) begin
      cand <= cand_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mcs_best.sv
// ----------------------------------------------------------------------------
// mcs_best
// Running best candidate, four-key ranking and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "maneuver_candidate_selector_top_macros.svh"

module mcs_best (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [mcs_pkg::TolWidth-1:0]  tol,
  input  wire logic                          cand_valid,
  input  wire mcs_pkg::cand_t                cand,
  output logic                               cand_ready,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               found,
  output logic signed [15:0]                 chosen_index
);
  import mcs_pkg::*;

  logic                  have_best;
  logic [IndexWidth-1:0] best_number;
  logic [ValWidth-1:0]   best_depth;
  logic [ValWidth-1:0]   best_pass_abs;
  logic [ValWidth-1:0]   best_term_abs;
  logic [ValWidth-1:0]   best_time;

  key_res_t              r_depth;
  key_res_t              r_pass;
  key_res_t              r_term;
  key_res_t              r_time;
  logic                  wins;
  logic                  take;
  logic                  advance;
  logic                  found_next;
  logic [IndexWidth-1:0] number_next;

  always_comb begin
    r_depth = key_cmp(cand.depth, best_depth, tol);
    r_pass  = key_cmp(cand.pass_abs, best_pass_abs, tol);
    r_term  = key_cmp(cand.term_abs, best_term_abs, tol);
    r_time  = key_cmp({1'b0, cand.travel}, best_time, tol);
    priority if (r_depth != KEY_TIE) begin
      wins = (r_depth == KEY_WIN);
    end else if (r_pass != KEY_TIE) begin
      wins = (r_pass == KEY_WIN);
    end else if (r_term != KEY_TIE) begin
      wins = (r_term == KEY_WIN);
    end else begin
      wins = (r_time == KEY_WIN);
    end
    take        = cand.valid && (!have_best || wins);
    found_next  = have_best || take;
    number_next = take ? cand.number : best_number;
  end

  // A last beat needs the result register free; other beats always move.
  assign cand_ready = !cand.last || !out_valid || out_ready;
  assign advance    = cand_valid && cand_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
    end else if (advance) begin
      have_best <= cand.last ? 1'b0 : found_next;
    end
    if (advance && take) begin
      best_number   <= cand.number;
      best_depth    <= cand.depth;
      best_pass_abs <= cand.pass_abs;
      best_term_abs <= cand.term_abs;
      best_time     <= {1'b0, cand.travel};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && cand.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance && cand.last) begin
      found        <= found_next;
      chosen_index <= found_next ? number_next : NO_INDEX;
    end
  end

  `MCS_ASSERT_NOW(a_no_index_when_empty, out_valid && !found, chosen_index == NO_INDEX)
  `MCS_ASSERT_NOW(a_best_nonnegative, have_best, !best_number[15])
  `MCS_ASSERT_NEXT(a_cleared_after_last, advance && cand.last, !have_best)
  `MCS_ASSERT_NOW(a_last_waits, cand_valid && cand.last && out_valid && !out_ready, !advance)

endmodule

`default_nettype wire
